/* rtl/tcw_pkg.sv */
// Shared types, constants and codes for the text console writer.
`default_nettype none

package tcw_pkg;

  // Screen geometry and the derived cell-address width.
  localparam int COLUMNS = 80;
  localparam int LINES   = 25;
  localparam int CELLS   = COLUMNS * LINES;
  localparam int ADDR_W  = $clog2(CELLS);

  // Fixed field widths of the request and result ports.
  localparam int COL_W  = 7;
  localparam int LINE_W = 5;
  localparam int ACT_W  = 2;

  // Command queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  // Action codes carried on the request port.
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Character codes and the attribute register's reset value.
  localparam logic [7:0] NEWLINE_CODE       = 8'd10;
  localparam logic [7:0] SPACE_CODE         = 8'd32;
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd2;

  // Classified command kinds.
  typedef enum logic [2:0] {
    KIND_PUT,
    KIND_NEWLINE,
    KIND_READ,
    KIND_CLEAR,
    KIND_NOP
  } kind_t;

  // One classified request as it travels through the command queue.
  typedef struct packed {
    kind_t             kind;
    logic              at_pos;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;
    logic [7:0]        character;
    logic [7:0]        attribute;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_BLANK,
    ST_FILL
  } state_t;

endpackage

`default_nettype wire

/* rtl/tcw_front.sv */
// Front end: accepts requests, classifies them and clamps their coordinates.
`default_nettype none

module tcw_front
  import tcw_pkg::*;
(
  input  wire logic              push,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [7:0]        character,
  input  wire logic              at_position,
  input  wire logic [COL_W-1:0]  column,
  input  wire logic [LINE_W-1:0] line,
  input  wire logic [7:0]        attribute,
  input  wire logic              q_full,
  output logic                   full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  // The queue's fill state is the request port's back pressure.
  assign full   = q_full;
  assign q_push = push;

  // Decode the action and clamp coordinates to the screen.
  always_comb begin
    q_cmd.at_pos    = at_position;
    q_cmd.character = character;
    q_cmd.attribute = attribute;
    q_cmd.col       = (column > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : column;
    q_cmd.line      = (line > LINE_W'(LINES - 1)) ? LINE_W'(LINES - 1) : line;
    case (action)
      ACT_PUT:   q_cmd.kind = (character == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PUT;
      ACT_READ:  q_cmd.kind = KIND_READ;
      ACT_CLEAR: q_cmd.kind = KIND_CLEAR;
      default:   q_cmd.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/tcw_cmd_fifo.sv */
// Short command queue that decouples the front end from the back end.
`default_nettype none

module tcw_cmd_fifo
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      rdata
);

  cmd_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/tcw_back.sv */
// Back end: cell memory, cursor, scroll and clear passes, and the result register.
`default_nettype none

module tcw_back
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              config_we,
  input  wire logic [7:0]        config_data,
  input  wire logic              q_empty,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [COL_W-1:0]       cursor_column,
  output logic [LINE_W-1:0]      cursor_line,
  output logic [7:0]             cell_character,
  output logic [7:0]             cell_attribute,
  output logic                   scrolled
);

  // Cell memory: character in the low byte, attribute in the high byte.
  logic [15:0]       mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_rdata;

  state_t            state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              mv_pending;
  logic [ADDR_W-1:0] mv_dst;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [LINE_W-1:0] cur_line, cur_line_next;
  logic [7:0]        def_attr;

  logic              out_valid, out_valid_next;
  logic [COL_W-1:0]  out_col, out_col_next;
  logic [LINE_W-1:0] out_line, out_line_next;
  logic [7:0]        out_char, out_char_next;
  logic [7:0]        out_attr, out_attr_next;
  logic              out_scrolled, out_scrolled_next;

  logic [COL_W-1:0]  pick_col;
  logic [LINE_W-1:0] pick_line;
  logic [ADDR_W-1:0] pick_addr;
  logic [COL_W:0]    col_inc;
  logic [LINE_W:0]   line_inc;
  logic [7:0]        attr_eff;
  logic              can_start;

  assign empty          = !out_valid;
  assign cursor_column  = out_col;
  assign cursor_line    = out_line;
  assign cell_character = out_char;
  assign cell_attribute = out_attr;
  assign scrolled       = out_scrolled;

  // Cell address and cursor advance for the command at the head of the queue.
  always_comb begin
    pick_col  = q_cmd.at_pos ? q_cmd.col : cur_col;
    pick_line = q_cmd.at_pos ? q_cmd.line : cur_line;
    pick_addr = ADDR_W'(pick_line) * ADDR_W'(COLUMNS) + ADDR_W'(pick_col);
    attr_eff  = (q_cmd.attribute == 8'd0) ? def_attr : q_cmd.attribute;
    col_inc   = (COL_W + 1)'(pick_col) + 1'b1;
    line_inc  = (LINE_W + 1)'(pick_line);
    if (q_cmd.kind == KIND_NEWLINE || col_inc == (COL_W + 1)'(COLUMNS)) begin
      col_inc  = '0;
      line_inc = (LINE_W + 1)'(pick_line) + 1'b1;
    end
  end

  // A new command starts only when the result register is free.
  assign can_start = !q_empty && (!out_valid || pop);

  // Sequencer: next state, memory port and result register.
  always_comb begin
    state_next        = state;
    ptr_next          = ptr;
    cur_col_next      = cur_col;
    cur_line_next     = cur_line;
    q_pop             = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = ptr;
    mem_wdata         = '0;
    mem_raddr         = pick_addr;
    out_valid_next    = out_valid && !pop;
    out_col_next      = out_col;
    out_line_next     = out_line;
    out_char_next     = out_char;
    out_attr_next     = out_attr;
    out_scrolled_next = out_scrolled;
    case (state)
      ST_INIT: begin
        // Power-up pass that zeroes every cell.
        mem_we = 1'b1;
        if (ptr == ADDR_W'(CELLS - 1)) begin
          ptr_next   = '0;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (can_start) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            KIND_PUT, KIND_NEWLINE: begin
              if (q_cmd.kind == KIND_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = pick_addr;
                mem_wdata = {attr_eff, q_cmd.character};
              end
              cur_col_next = COL_W'(col_inc);
              if (line_inc == (LINE_W + 1)'(LINES)) begin
                cur_line_next = LINE_W'(LINES - 1);
                ptr_next      = '0;
                state_next    = ST_MOVE;
              end else begin
                cur_line_next     = LINE_W'(line_inc);
                out_valid_next    = 1'b1;
                out_col_next      = COL_W'(col_inc);
                out_line_next     = LINE_W'(line_inc);
                out_char_next     = 8'd0;
                out_attr_next     = 8'd0;
                out_scrolled_next = 1'b0;
              end
            end
            KIND_READ: begin
              state_next = ST_READ;
            end
            KIND_CLEAR: begin
              cur_col_next  = '0;
              cur_line_next = '0;
              ptr_next      = '0;
              state_next    = ST_FILL;
            end
            default: begin
              out_valid_next    = 1'b1;
              out_col_next      = cur_col;
              out_line_next     = cur_line;
              out_char_next     = 8'd0;
              out_attr_next     = 8'd0;
              out_scrolled_next = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        // The read data, registered from the address given in ST_IDLE, is ready in this state.
        out_valid_next    = 1'b1;
        out_col_next      = cur_col;
        out_line_next     = cur_line;
        out_char_next     = mem_rdata[7:0];
        out_attr_next     = mem_rdata[15:8];
        out_scrolled_next = 1'b0;
        state_next        = ST_IDLE;
      end
      ST_MOVE: begin
        // Read one line below and write the previous cell read, one per cycle.
        mem_raddr = ptr + ADDR_W'(COLUMNS);
        mem_we    = mv_pending;
        mem_waddr = mv_dst;
        mem_wdata = mem_rdata;
        if (ptr == ADDR_W'(CELLS - COLUMNS - 1)) begin
          ptr_next   = ADDR_W'(CELLS - COLUMNS);
          state_next = ST_BLANK;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ST_BLANK: begin
        // Finish the last move, then blank the bottom line.
        mem_we = 1'b1;
        if (mv_pending) begin
          mem_waddr = mv_dst;
          mem_wdata = mem_rdata;
        end else begin
          mem_wdata = {def_attr, SPACE_CODE};
          if (ptr == ADDR_W'(CELLS - 1)) begin
            ptr_next          = '0;
            state_next        = ST_IDLE;
            out_valid_next    = 1'b1;
            out_col_next      = cur_col;
            out_line_next     = cur_line;
            out_char_next     = 8'd0;
            out_attr_next     = 8'd0;
            out_scrolled_next = 1'b1;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end
      end
      ST_FILL: begin
        // Clear pass: every cell becomes a space with the default attribute.
        mem_we    = 1'b1;
        mem_wdata = {def_attr, SPACE_CODE};
        if (ptr == ADDR_W'(CELLS - 1)) begin
          ptr_next          = '0;
          state_next        = ST_IDLE;
          out_valid_next    = 1'b1;
          out_col_next      = cur_col;
          out_line_next     = cur_line;
          out_char_next     = 8'd0;
          out_attr_next     = 8'd0;
          out_scrolled_next = 1'b0;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: pass pointer, cursor, attribute and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      mv_pending <= 1'b0;
      cur_col    <= '0;
      cur_line   <= '0;
      def_attr   <= DEFAULT_ATTR_RESET;
      out_valid  <= 1'b0;
    end else begin
      ptr        <= ptr_next;
      mv_pending <= (state == ST_MOVE);
      cur_col    <= cur_col_next;
      cur_line   <= cur_line_next;
      out_valid  <= out_valid_next;
      if (config_we) begin
        def_attr <= config_data;
      end
    end
  end

  // Result payload and move destination need no reset.
  always_ff @(posedge clk) begin
    mv_dst       <= ptr;
    out_col      <= out_col_next;
    out_line     <= out_line_next;
    out_char     <= out_char_next;
    out_attr     <= out_attr_next;
    out_scrolled <= out_scrolled_next;
  end

  // Cell memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

`ifndef ASSERT_OFF
  // The cursor always stays on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(COLUMNS)) && (cur_line < LINE_W'(LINES)))
    else $error("cursor left the screen");

  // No command leaves the queue while a pass or read is under way.
  a_no_pop_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop)
    else $error("command taken while busy");

  // A waiting result is held until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(out_col) && $stable(out_scrolled)))
    else $error("result lost before it was taken");

  // Scroll moves never write into the bottom line.
  a_move_target: assert property (@(posedge clk) disable iff (rst)
    mv_pending |-> (mv_dst < ADDR_W'(CELLS - COLUMNS)))
    else $error("scroll move wrote the bottom line");

  // Leaving the read state always registers a valid result that flags no scroll.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (out_valid && !out_scrolled))
    else $error("read result missing");
`endif

endmodule

`default_nettype wire

/* rtl/text_console_writer_top.sv */
// Top level of the text console writer: front end, command queue and back end.
//
//   Channel   Handshake          Payload
//   request   push / full        action, character, at_position, column, line, attribute
//   result    empty / pop        cursor_column, cursor_line, cell_character,
//                                cell_attribute, scrolled
//   config    config_we          config_data (default attribute)
//
// A put or newline is carried out in the idle state, and a read passes through
// the read state as well, since the cell memory has a registered read. A put that
// scrolls runs a move pass over every cell below the top line and then blanks
// the bottom line; a clear runs a fill pass over every cell. After reset a
// zeroing pass over every cell runs before the first request is carried out;
// requests are queued meanwhile up to the queue depth.
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              config_we,
  input  wire logic [7:0]        config_data,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [7:0]        character,
  input  wire logic              at_position,
  input  wire logic [COL_W-1:0]  column,
  input  wire logic [LINE_W-1:0] line,
  input  wire logic [7:0]        attribute,
  output logic                   empty,
  input  wire logic              pop,
  output logic [COL_W-1:0]       cursor_column,
  output logic [LINE_W-1:0]      cursor_line,
  output logic [7:0]             cell_character,
  output logic [7:0]             cell_attribute,
  output logic                   scrolled
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_wcmd;
  cmd_t q_rcmd;

  // Request classification.
  tcw_front u_front (
    .push        (push),
    .action      (action),
    .character   (character),
    .at_position (at_position),
    .column      (column),
    .line        (line),
    .attribute   (attribute),
    .q_full      (q_full),
    .full        (full),
    .q_push      (q_push),
    .q_cmd       (q_wcmd)
  );

  // Command queue.
  tcw_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wcmd),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rcmd)
  );

  // Execution against the cell memory.
  tcw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .config_we      (config_we),
    .config_data    (config_data),
    .q_empty        (q_empty),
    .q_cmd          (q_rcmd),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .cursor_column  (cursor_column),
    .cursor_line    (cursor_line),
    .cell_character (cell_character),
    .cell_attribute (cell_attribute),
    .scrolled       (scrolled)
  );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the text console writer: directed, extreme-attribute and random traffic.
module tb;
  import tcw_pkg::*;

  // Action code the block leaves unused; it must change nothing.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // A scroll or a clear takes about one screen pass; settle a little longer than that.
  localparam int PASS_SETTLE  = CELLS + 2 * COLUMNS;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int REQUEST_GOAL = 650;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [7:0]        character;
    logic              at_position;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic [7:0]        attribute;
  } console_request_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [LINE_W-1:0] cursor_line;
    logic [7:0]        cell_character;
    logic [7:0]        cell_attribute;
    logic              scrolled;
  } console_result_t;

  logic              clk;
  logic              rst;
  logic              config_we;
  logic [7:0]        config_data;
  logic              push;
  logic              full;
  logic [ACT_W-1:0]  action;
  logic [7:0]        character;
  logic              at_position;
  logic [COL_W-1:0]  column;
  logic [LINE_W-1:0] line;
  logic [7:0]        attribute;
  logic              empty;
  logic              pop;
  logic [COL_W-1:0]  cursor_column;
  logic [LINE_W-1:0] cursor_line;
  logic [7:0]        cell_character;
  logic [7:0]        cell_attribute;
  logic              scrolled;

  // Predicted screen contents: attribute in the high byte, character in the low byte.
  logic [15:0]       screen_cells [CELLS];
  int unsigned       cursor_cell;
  logic [7:0]        default_attr;

  console_result_t   expected_results [$];
  int                error_count;
  int                requests_sent;
  int                results_checked;
  int                cycle_count;
  bit                sender_gaps_on;

  text_console_writer_top dut (
    .clk            (clk),
    .rst            (rst),
    .config_we      (config_we),
    .config_data    (config_data),
    .push           (push),
    .full           (full),
    .action         (action),
    .character      (character),
    .at_position    (at_position),
    .column         (column),
    .line           (line),
    .attribute      (attribute),
    .empty          (empty),
    .pop            (pop),
    .cursor_column  (cursor_column),
    .cursor_line    (cursor_line),
    .cell_character (cell_character),
    .cell_attribute (cell_attribute),
    .scrolled       (scrolled)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Print one mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in result %0d, %s: got %0d, expected %0d",
             results_checked, what, got, want);
    error_count++;
  endtask

  function automatic console_request_t make_request(input logic [ACT_W-1:0] act,
      input logic [7:0] ch, input logic at_pos, input logic [COL_W-1:0] col,
      input logic [LINE_W-1:0] row, input logic [7:0] attr);
    console_request_t r;
    r.action      = act;
    r.character   = ch;
    r.at_position = at_pos;
    r.column      = col;
    r.line        = row;
    r.attribute   = attr;
    return r;
  endfunction

  // Cell addressed by a request; out-of-range coordinates clamp to the last column or line.
  function automatic int unsigned target_cell(input console_request_t r);
    int unsigned col;
    int unsigned row;
    if (!r.at_position) return cursor_cell;
    col = (r.column > COLUMNS - 1) ? COLUMNS - 1 : r.column;
    row = (r.line > LINES - 1) ? LINES - 1 : r.line;
    return row * COLUMNS + col;
  endfunction

  // Apply one request to the predicted screen and return the result it produces.
  function automatic console_result_t console_step(input console_request_t r);
    console_result_t res;
    int unsigned     pos;
    logic [7:0]      attr;
    int              k;
    res = '0;
    case (r.action)
      ACT_PUT: begin
        attr = (r.attribute == 8'd0) ? default_attr : r.attribute;
        pos = target_cell(r);
        // A newline writes nothing and jumps to the last column of its line.
        if (r.character == NEWLINE_CODE) pos = (pos / COLUMNS) * COLUMNS + COLUMNS - 1;
        else screen_cells[pos] = {attr, r.character};
        pos++;
        // Running off the last cell scrolls up and blanks the bottom line.
        if (pos >= CELLS) begin
          for (k = 0; k < CELLS - COLUMNS; k++) screen_cells[k] = screen_cells[k + COLUMNS];
          for (k = CELLS - COLUMNS; k < CELLS; k++) screen_cells[k] = {default_attr, SPACE_CODE};
          pos -= COLUMNS;
          res.scrolled = 1'b1;
        end
        cursor_cell = pos;
      end
      ACT_READ: begin
        pos = target_cell(r);
        res.cell_character = screen_cells[pos][7:0];
        res.cell_attribute = screen_cells[pos][15:8];
      end
      ACT_CLEAR: begin
        for (k = 0; k < CELLS; k++) screen_cells[k] = {default_attr, SPACE_CODE};
        cursor_cell = 0;
      end
      default: ;
    endcase
    res.cursor_column = COL_W'(cursor_cell % COLUMNS);
    res.cursor_line   = LINE_W'(cursor_cell / COLUMNS);
    return res;
  endfunction

  // Send one request after a random gap and record its predicted result on acceptance.
  task automatic send_request(input console_request_t r);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    action      <= r.action;
    character   <= r.character;
    at_position <= r.at_position;
    column      <= r.column;
    line        <= r.line;
    attribute   <= r.attribute;
    do @(posedge clk); while (full);
    expected_results.push_back(console_step(r));
    requests_sent++;
  endtask

  // Stop sending and wait until every predicted result has been taken, then settle.
  task automatic wait_idle(input int settle);
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Change the default attribute only while the block has no work left.
  task automatic set_default_attribute(input logic [7:0] value);
    wait_idle(PASS_SETTLE);
    @(negedge clk);
    config_we   <= 1'b1;
    config_data <= value;
    @(negedge clk);
    config_we   <= 1'b0;
    default_attr = value;
  endtask

  // Coordinates mostly on screen, sometimes anywhere the field width allows.
  function automatic logic [COL_W-1:0] pick_column();
    return ($urandom_range(0, 4) == 0) ? COL_W'($urandom) : COL_W'($urandom_range(0, COLUMNS - 1));
  endfunction

  function automatic logic [LINE_W-1:0] pick_line(input bit near_bottom);
    if (near_bottom) return LINE_W'($urandom_range(LINES - 3, LINES - 1));
    return ($urandom_range(0, 4) == 0) ? LINE_W'($urandom) : LINE_W'($urandom_range(0, LINES - 1));
  endfunction

  // Corner cases of every action under the reset attribute.
  task automatic test_edge_cases();
    // Read of a cell that only the reset zeroing has touched.
    send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd0, 5'd0, 8'd0));
    // Zero attribute takes the default; cursor advances.
    send_request(make_request(ACT_PUT, "A", 1'b0, 7'd127, 5'd31, 8'd0));
    // All-ones coordinates clamp to the last cell, so this put scrolls.
    send_request(make_request(ACT_PUT, 8'hFF, 1'b1, 7'd127, 5'd31, 8'hFF));
    send_request(make_request(ACT_READ, 8'hFF, 1'b1, 7'd127, 5'd31, 8'hFF));
    send_request(make_request(ACT_READ, 8'd0, 1'b1, COL_W'(COLUMNS - 1), LINE_W'(LINES - 2), 8'd0));
    send_request(make_request(ACT_PUT, 8'd0, 1'b0, 7'd0, 5'd0, 8'd1));
    // Newline on the bottom line scrolls.
    send_request(make_request(ACT_PUT, NEWLINE_CODE, 1'b0, 7'd0, 5'd0, 8'd0));
    // Positioned newline goes below the given line.
    send_request(make_request(ACT_PUT, NEWLINE_CODE, 1'b1, 7'd40, 5'd3, 8'd7));
    send_request(make_request(ACT_PUT, NEWLINE_CODE, 1'b1, 7'd85, LINE_W'(LINES - 1), 8'd7));
    // Put in the last column wraps to the next line.
    send_request(make_request(ACT_PUT, "Z", 1'b1, COL_W'(COLUMNS - 1), 5'd10, 8'h55));
    send_request(make_request(ACT_READ, 8'd0, 1'b1, COL_W'(COLUMNS - 1), 5'd10, 8'd0));
    send_request(make_request(ACT_UNUSED, 8'hAA, 1'b1, 7'd42, 5'd21, 8'hAA));
    send_request(make_request(ACT_READ, 8'd0, 1'b0, 7'd0, 5'd0, 8'd0));
    // Clear blanks every cell and homes the cursor.
    send_request(make_request(ACT_CLEAR, 8'h5A, 1'b1, 7'd12, 5'd12, 8'h33));
    send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd0, 5'd0, 8'd0));
    send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd127, 5'd31, 8'd0));
    send_request(make_request(ACT_PUT, 8'hAA, 1'b1, 7'd42, 5'd21, 8'h55));
    send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd42, 5'd21, 8'd0));
    send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd43, 5'd21, 8'd0));
  endtask

  // Both extreme default attributes through puts, scrolls and clears.
  task automatic test_attribute_extremes();
    logic [7:0] extremes [2];
    extremes[0] = 8'h00;
    extremes[1] = 8'hFF;
    foreach (extremes[i]) begin
      set_default_attribute(extremes[i]);
      send_request(make_request(ACT_PUT, "q", 1'b1, 7'd5, 5'd5, 8'd0));
      send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd5, 5'd5, 8'd0));
      send_request(make_request(ACT_PUT, NEWLINE_CODE, 1'b1, 7'd0, LINE_W'(LINES - 1), 8'd0));
      send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd9, LINE_W'(LINES - 1), 8'd0));
      send_request(make_request(ACT_CLEAR, 8'd0, 1'b0, 7'd0, 5'd0, 8'd0));
      send_request(make_request(ACT_READ, 8'd0, 1'b1, 7'd70, 5'd20, 8'd0));
    end
  endtask

  // Runs of text at the cursor, read-back bursts, noise, clears, drains and attribute changes.
  task automatic test_random_traffic();
    int         pick;
    int         n;
    bit         near_bottom;
    logic [7:0] ch;
    logic [7:0] attr;
    while (requests_sent < REQUEST_GOAL) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // Text run, often starting near the bottom so it scrolls.
        near_bottom = $urandom_range(0, 1);
        if ($urandom_range(0, 2) != 0)
          send_request(make_request(ACT_PUT, 8'($urandom), 1'b1, pick_column(),
                                    pick_line(near_bottom), 8'($urandom)));
        n = $urandom_range(5, 30);
        repeat (n) begin
          ch   = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : 8'($urandom);
          attr = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
          send_request(make_request(ACT_PUT, ch, 1'b0, COL_W'($urandom), LINE_W'($urandom), attr));
        end
      end else if (pick < 75) begin
        // Read-back burst over the screen and at the cursor.
        n = $urandom_range(3, 8);
        repeat (n)
          send_request(make_request(ACT_READ, 8'($urandom), ($urandom_range(0, 4) != 0),
                                    pick_column(), pick_line(1'b0), 8'($urandom)));
      end else if (pick < 87) begin
        // Unconstrained items, including the unused action.
        n = $urandom_range(2, 6);
        repeat (n)
          send_request(make_request(ACT_W'($urandom), 8'($urandom), 1'($urandom),
                                    COL_W'($urandom), LINE_W'($urandom), 8'($urandom)));
      end else if (pick < 90) begin
        send_request(make_request(ACT_CLEAR, 8'($urandom), 1'($urandom),
                                  COL_W'($urandom), LINE_W'($urandom), 8'($urandom)));
      end else if (pick < 95) begin
        // Let the block run dry before carrying on.
        wait_idle(0);
      end else begin
        case ($urandom_range(0, 3))
          0:       set_default_attribute(8'h00);
          1:       set_default_attribute(8'hFF);
          default: set_default_attribute(8'($urandom));
        endcase
      end
    end
  endtask

  // Take results with random stalls and compare each with the oldest prediction.
  initial begin : result_checker
    console_result_t got;
    console_result_t want;
    int              stall;
    int              mode_left;
    bit              stalls_on;
    pop       = 1'b0;
    mode_left = 0;
    stalls_on = 1'b1;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stalls_on = ($urandom_range(0, 3) != 0);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      stall = stalls_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = '{cursor_column, cursor_line, cell_character, cell_attribute, scrolled};
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.cursor_column !== want.cursor_column)
          report_mismatch("cursor_column", got.cursor_column, want.cursor_column);
        if (got.cursor_line !== want.cursor_line)
          report_mismatch("cursor_line", got.cursor_line, want.cursor_line);
        if (got.cell_character !== want.cell_character)
          report_mismatch("cell_character", got.cell_character, want.cell_character);
        if (got.cell_attribute !== want.cell_attribute)
          report_mismatch("cell_attribute", got.cell_attribute, want.cell_attribute);
        if (got.scrolled !== want.scrolled)
          report_mismatch("scrolled", got.scrolled, want.scrolled);
      end
      results_checked++;
    end
  end

  // Main sequence: reset, then each test in turn, then drain and judge.
  initial begin
    int k;
    rst             = 1'b1;
    config_we       = 1'b0;
    config_data     = 8'd0;
    push            = 1'b0;
    action          = ACT_PUT;
    character       = 8'd0;
    at_position     = 1'b0;
    column          = '0;
    line            = '0;
    attribute       = 8'd0;
    error_count     = 0;
    requests_sent   = 0;
    results_checked = 0;
    sender_gaps_on  = 1'b1;
    for (k = 0; k < CELLS; k++) screen_cells[k] = 16'h0000;
    cursor_cell  = 0;
    default_attr = DEFAULT_ATTR_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_attribute_extremes();
    test_random_traffic();

    wait_idle(PASS_SETTLE);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
